>>> rtl/core/nat_pkg.sv
// nat_pkg: shared constants, stream field layout, controller states and the
// command/status structs between nat_ctrl and nat_dpath.
// No dependencies.
`timescale 1ns / 1ps

package nat_pkg;

	// Mesh sizing
	localparam int MAX_PARTICLES = 1024;
	localparam int COORD_BITS    = 16;

	localparam int IDX_W  = $clog2(MAX_PARTICLES);
	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

	// Squared distance and its root
	localparam int D2_W   = 2 * COORD_BITS + 2;
	localparam int SQRT_W = COORD_BITS + 1;
	localparam int REM_W  = SQRT_W + 3;
	localparam int ITER_W = $clog2(SQRT_W + 1);
	localparam logic [ITER_W-1:0] SQRT_STEPS = ITER_W'(SQRT_W);

	// Field widths on the stream ports
	localparam int POS_W  = 16;
	localparam int QIDX_W = 10;
	localparam int AIDX_W = 10;
	localparam int TLEN_W = 17;

	// Slave side: tuser = {first_of_set, action}
	localparam int S_USER_W = 2;
	localparam int U_ACTION = 0;
	localparam int U_FIRST  = 1;

	// Slave side tdata layout
	localparam int S_DATA_W = 64;
	localparam int D_POSX   = 0;
	localparam int D_POSY   = D_POSX + POS_W;
	localparam int D_POSZ   = D_POSY + POS_W;
	localparam int D_ANCH   = D_POSZ + POS_W;
	localparam int D_QIDX   = D_ANCH + 1;

	// Master side tdata = {pad, tether_length, anchor_index}
	localparam int M_DATA_W = 32;
	localparam int M_PAD_W  = M_DATA_W - AIDX_W - TLEN_W;

	// Action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ME,
		ST_SCAN,
		ST_ROOT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic me_cap;
		logic scan_run;
		logic sqrt_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic q_ok;
		logic has_anchor;
		logic scan_busy;
		logic root_busy;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/nearest_anchor_tether.sv
// nearest_anchor_tether: top level; joins the controller and the datapath.
// Depends on nat_pkg, nat_ctrl, nat_dpath (which holds nat_isqrt).
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: particle or query, tuser: action, first_of_set
//  m_*      out  m_tvalid/m_tready  tdata: anchor_index, tether_length, tuser: no_anchor
//
// A load is written as it is accepted. For a query with A stored anchors,
// the scan reads one anchor per cycle through the single particle memory read
// port, then a 17-step square root runs, one result bit per cycle.
// After reset both counts are zero; memory contents are not cleared.
// s_tready is low while a query is in work; a result waiting in the output
// register does not block loads or the start of the next query.
`timescale 1ns / 1ps

module nearest_anchor_tether import nat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [48] anchored,
	// [58:49] query_index, [63:59] zero
	input  logic [S_DATA_W-1:0] s_tdata,
	// [0] action, [1] first_of_set
	input  logic [S_USER_W-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [9:0] anchor_index, [26:10] tether_length, [31:27] zero
	output logic [M_DATA_W-1:0] m_tdata,
	// [0] no_anchor
	output logic                m_tuser
);

	cmd_t cmd;
	sts_t sts;

	nat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nat_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/core/nat_isqrt.sv
// nat_isqrt: multi-cycle floor integer square root, one result bit per cycle.
// Depends on nat_pkg (D2_W, SQRT_W, REM_W, ITER_W).
`timescale 1ns / 1ps

module nat_isqrt import nat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [D2_W-1:0]   radicand,
	output logic              busy,
	output logic [SQRT_W-1:0] root
);

	logic [ITER_W-1:0] cnt_q;
	logic [D2_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [SQRT_W-1:0] root_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// One restoring step: bring down two bits, try (root << 2) | 1
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[D2_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = (rem_sh >= trial);
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= SQRT_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - ITER_W'(1);
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[D2_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[SQRT_W-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;

endmodule

>>> rtl/core/nat_ctrl.sv
// nat_ctrl: controller state machine; owns s_tready and issues datapath commands.
// Depends on nat_pkg (state_t, cmd_t, sts_t).
`timescale 1ns / 1ps

module nat_ctrl import nat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && sts.q_ok) begin
					state_nx = sts.has_anchor ? ST_ME : ST_EMIT;
				end
			end
			ST_ME: begin
				state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.scan_busy) begin
					state_nx = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (!sts.root_busy) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.accept     = s_tvalid && (state_q == ST_IDLE);
		cmd.me_cap     = (state_q == ST_ME);
		cmd.scan_run   = (state_q == ST_SCAN);
		cmd.sqrt_start = (state_q == ST_SCAN) && !sts.scan_busy;
		cmd.out_load   = (state_q == ST_EMIT) && sts.out_free;
	end

endmodule

>>> rtl/core/nat_dpath.sv
// nat_dpath: particle and anchor memories, counters, the nearest-anchor scan
// pipeline, the square root unit and the result register.
// Depends on nat_pkg and nat_isqrt.
`timescale 1ns / 1ps

module nat_dpath import nat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [S_USER_W-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser
);

	// Memories (contents undefined until written)
	logic [3*COORD_BITS-1:0] store [MAX_PARTICLES];
	logic [IDX_W-1:0]        alist [MAX_PARTICLES];

	// Input fields
	logic                    action;
	logic                    first;
	logic                    anchored;
	logic [POS_W-1:0]        pos_x, pos_y, pos_z;
	logic [QIDX_W-1:0]       qidx;
	logic [COORD_BITS+POS_W-1:0] x_ext, y_ext, z_ext;
	logic [3*COORD_BITS-1:0] packed_pos;
	logic [IDX_W+QIDX_W-1:0] qidx_ext;
	logic [IDX_W-1:0]        qidx_mem;
	logic [CNT_W+QIDX_W-1:0] qidx_cmp, pc_cmp;

	// Counters
	logic [CNT_W-1:0] pc_q, ac_q;
	logic [CNT_W-1:0] pc_base, ac_base;
	logic             ld_ok;
	logic             ld_fire;

	// Scan
	logic [CNT_W-1:0]        k_q;
	logic                    issue;
	logic [3*COORD_BITS-1:0] me_q;
	logic [3*COORD_BITS-1:0] store_rd_q;
	logic [IDX_W-1:0]        store_raddr;
	logic [IDX_W-1:0]        list_rd_s1;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]        ai_s2, ai_s3, ai_s4;
	logic signed [COORD_BITS:0]     dx, dy, dz;
	logic signed [2*COORD_BITS+1:0] sqx, sqy, sqz;
	logic [2*COORD_BITS-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [D2_W-1:0]         d2_s4;
	logic                    found_q;
	logic [D2_W-1:0]         best_q;
	logic [IDX_W-1:0]        best_ai_q;
	logic                    na_q;

	// Root and result
	logic                     root_busy;
	logic [SQRT_W-1:0]        root;
	logic [SQRT_W+TLEN_W-1:0] root_ext;
	logic [IDX_W+AIDX_W-1:0]  ai_ext;
	logic                     m_tvalid_q;
	logic [AIDX_W-1:0]        aidx_q;
	logic [TLEN_W-1:0]        tlen_q;
	logic                     na_out_q;

	// Field extraction
	always_comb begin
		action     = s_tuser[U_ACTION];
		first      = s_tuser[U_FIRST];
		pos_x      = s_tdata[D_POSX +: POS_W];
		pos_y      = s_tdata[D_POSY +: POS_W];
		pos_z      = s_tdata[D_POSZ +: POS_W];
		anchored   = s_tdata[D_ANCH];
		qidx       = s_tdata[D_QIDX +: QIDX_W];
		x_ext      = {{COORD_BITS{1'b0}}, pos_x};
		y_ext      = {{COORD_BITS{1'b0}}, pos_y};
		z_ext      = {{COORD_BITS{1'b0}}, pos_z};
		packed_pos = {z_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0],
			x_ext[COORD_BITS-1:0]};
		qidx_ext   = {{IDX_W{1'b0}}, qidx};
		qidx_mem   = qidx_ext[IDX_W-1:0];
		qidx_cmp   = {{CNT_W{1'b0}}, qidx};
		pc_cmp     = {{QIDX_W{1'b0}}, pc_q};
	end

	// Load bookkeeping: first_of_set restarts both counts
	always_comb begin
		pc_base = first ? '0 : pc_q;
		ac_base = first ? '0 : ac_q;
		ld_ok   = (pc_base < MAX_CNT);
		ld_fire = cmd.accept && (action == ACT_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			ac_q <= '0;
		end else if (ld_fire) begin
			pc_q <= ld_ok ? (pc_base + CNT_W'(1)) : pc_base;
			ac_q <= (ld_ok && anchored) ? (ac_base + CNT_W'(1)) : ac_base;
		end
	end

	// Memory ports: one write and one registered read each
	assign store_raddr = v_s1 ? list_rd_s1 : qidx_mem;

	always_ff @(posedge clk) begin
		if (ld_fire && ld_ok) begin
			store[pc_base[IDX_W-1:0]] <= packed_pos;
			if (anchored) begin
				alist[ac_base[IDX_W-1:0]] <= pc_base[IDX_W-1:0];
			end
		end
		store_rd_q <= store[store_raddr];
		list_rd_s1 <= alist[k_q[IDX_W-1:0]];
	end

	// Query status
	always_comb begin
		sts            = '0;
		sts.q_ok       = (action == ACT_QUERY) && (qidx_cmp < pc_cmp);
		sts.has_anchor = (ac_q != '0);
		sts.scan_busy  = (k_q < ac_q) || v_s1 || v_s2 || v_s3 || v_s4;
		sts.root_busy  = root_busy;
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	assign issue = cmd.scan_run && (k_q < ac_q);

	// Scan control: anchor counter, stage valids, best-so-far flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			found_q <= 1'b0;
			na_q    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.accept && sts.q_ok) begin
				k_q     <= '0;
				found_q <= 1'b0;
				na_q    <= (ac_q == '0);
			end else begin
				if (issue) begin
					k_q <= k_q + CNT_W'(1);
				end
				if (v_s4 && (!found_q || d2_s4 < best_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Per-axis differences and squares
	always_comb begin
		dx  = $signed({store_rd_q[COORD_BITS-1], store_rd_q[COORD_BITS-1:0]})
			- $signed({me_q[COORD_BITS-1], me_q[COORD_BITS-1:0]});
		dy  = $signed({store_rd_q[2*COORD_BITS-1], store_rd_q[COORD_BITS +: COORD_BITS]})
			- $signed({me_q[2*COORD_BITS-1], me_q[COORD_BITS +: COORD_BITS]});
		dz  = $signed({store_rd_q[3*COORD_BITS-1], store_rd_q[2*COORD_BITS +: COORD_BITS]})
			- $signed({me_q[3*COORD_BITS-1], me_q[2*COORD_BITS +: COORD_BITS]});
		sqx = dx * dx;
		sqy = dy * dy;
		sqz = dz * dz;
	end

	// Scan payload stages
	always_ff @(posedge clk) begin
		if (cmd.me_cap) begin
			me_q <= store_rd_q;
		end
		ai_s2  <= list_rd_s1;
		ai_s3  <= ai_s2;
		sqx_s3 <= sqx[2*COORD_BITS-1:0];
		sqy_s3 <= sqy[2*COORD_BITS-1:0];
		sqz_s3 <= sqz[2*COORD_BITS-1:0];
		ai_s4  <= ai_s3;
		d2_s4  <= {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};
		// strict less-than keeps the earlier anchor on a tie
		if (v_s4 && (!found_q || d2_s4 < best_q)) begin
			best_q    <= d2_s4;
			best_ai_q <= ai_s4;
		end
	end

	nat_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (best_q),
		.busy     (root_busy),
		.root     (root)
	);

	assign root_ext = {{TLEN_W{1'b0}}, root};
	assign ai_ext   = {{AIDX_W{1'b0}}, best_ai_q};

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			aidx_q   <= na_q ? '0 : ai_ext[AIDX_W-1:0];
			tlen_q   <= na_q ? '0 : root_ext[TLEN_W-1:0];
			na_out_q <= na_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, tlen_q, aidx_q};
	assign m_tuser  = na_out_q;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for nearest_anchor_tether. Drives particle loads and
// tether queries on stream ports; checks each result by local predictor or typed row.
// Depends on nat_pkg and the nearest_anchor_tether RTL.
`timescale 1ns / 1ps

module tb_top;
	import nat_pkg::*;

	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int PHASE_A_END  = 450;
	localparam int TOTAL_ITEMS  = 1700;
	localparam int MAX_SHOWN    = 40;

	typedef enum int {
		CHK_MODEL,
		CHK_NONE,
		CHK_TYPED
	} chk_mode_t;

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_TIGHT,
		SPREAD_EDGE
	} coord_mode_t;

	typedef struct {
		logic                     act;
		logic                     first;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  pz;
		logic                     anch;
		logic [QIDX_W-1:0]        qidx;
	} mesh_req_t;

	typedef struct {
		logic [AIDX_W-1:0] aidx;
		logic [TLEN_W-1:0] tlen;
		logic              none;
	} tether_t;

	typedef struct {
		mesh_req_t req;
		chk_mode_t mode;
		tether_t   want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [S_USER_W-1:0] s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	nearest_anchor_tether u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Predictor copy of the mesh
	logic signed [POS_W-1:0] mesh_x [MAX_PARTICLES];
	logic signed [POS_W-1:0] mesh_y [MAX_PARTICLES];
	logic signed [POS_W-1:0] mesh_z [MAX_PARTICLES];
	int                      anchor_ids [MAX_PARTICLES];
	int                      mesh_cnt = 0;
	int                      anchor_cnt = 0;

	tether_t  tether_due [$];
	dir_row_t dir_rows [$];
	bit       tx_idle_en = 1'b1;
	bit       rx_idle_en = 1'b1;
	int       sent_cnt = 0;
	int       err_cnt = 0;
	int       quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint root_floor(input longint v);
		longint r;
		r = 0;
		for (int b = TLEN_W; b >= 0; b--) begin
			longint t;
			t = r | (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Updates the mesh copy; for a query inside the mesh returns the expected tether
	task automatic tether_predict(input mesh_req_t r, output bit got, output tether_t res);
		longint best, d2, dx, dy, dz;
		int     q, a;
		got = 1'b0;
		res.aidx = '0;
		res.tlen = '0;
		res.none = 1'b0;
		if (r.act == ACT_LOAD) begin
			if (r.first) begin
				mesh_cnt = 0;
				anchor_cnt = 0;
			end
			// a load into a full store is dropped
			if (mesh_cnt < MAX_PARTICLES) begin
				mesh_x[mesh_cnt] = r.px;
				mesh_y[mesh_cnt] = r.py;
				mesh_z[mesh_cnt] = r.pz;
				if (r.anch) begin
					anchor_ids[anchor_cnt] = mesh_cnt;
					anchor_cnt++;
				end
				mesh_cnt++;
			end
		end else if (int'(r.qidx) < mesh_cnt) begin
			got = 1'b1;
			if (anchor_cnt == 0) begin
				res.none = 1'b1;
			end else begin
				q = int'(r.qidx);
				best = -1;
				// strict less-than keeps the earliest anchor on a tie
				for (int k = 0; k < anchor_cnt; k++) begin
					a = anchor_ids[k];
					dx = longint'(mesh_x[a]) - longint'(mesh_x[q]);
					dy = longint'(mesh_y[a]) - longint'(mesh_y[q]);
					dz = longint'(mesh_z[a]) - longint'(mesh_z[q]);
					d2 = dx * dx + dy * dy + dz * dz;
					if (best < 0 || d2 < best) begin
						best = d2;
						res.aidx = AIDX_W'(a);
					end
				end
				res.tlen = TLEN_W'(root_floor(best));
			end
		end
	endtask

	task automatic flag_mismatch(input string msg);
		if (err_cnt < MAX_SHOWN)
			$display("[%0t] MISMATCH: %s", $time, msg);
		err_cnt++;
	endtask

	// One transfer on the slave side; valid stays high afterwards
	task automatic send_req(input mesh_req_t r, output bit got, output tether_t res);
		int gap;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - D_QIDX - QIDX_W){1'b0}}, r.qidx, r.anch, r.pz, r.py, r.px};
		s_tuser  <= {r.first, r.act};
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
		tether_predict(r, got, res);
	endtask

	task automatic issue(input mesh_req_t r);
		bit      got;
		tether_t res;
		send_req(r, got, res);
		if (got)
			tether_due.push_back(res);
	endtask

	// Sender holds off until every pending result has come out
	task automatic drain_wait();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tether_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [POS_W-1:0] pick_coord(input coord_mode_t cm);
		case (cm)
			SPREAD_TIGHT: return POS_W'(int'($urandom_range(0, 6)) - 3);
			SPREAD_EDGE: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					3: return 16'shffff;
					default: return POS_W'($urandom);
				endcase
			end
			default: return POS_W'($urandom);
		endcase
	endfunction

	// Loads and queries of one mesh, mixed in random order; the first item is a load
	task automatic run_mesh(input int n_load, input int n_query, input coord_mode_t cm,
			input int anch_pct, input bit fresh);
		mesh_req_t r;
		int        loads_done;
		loads_done = 0;
		while (n_load > 0 || n_query > 0) begin
			if (n_load > 0 && (n_query == 0 || loads_done == 0 || $urandom_range(0, 1) == 0)) begin
				r.act   = ACT_LOAD;
				r.first = fresh && loads_done == 0;
				r.px    = pick_coord(cm);
				r.py    = pick_coord(cm);
				r.pz    = pick_coord(cm);
				r.anch  = ($urandom_range(0, 99) < anch_pct) || (mesh_cnt == MAX_PARTICLES - 1);
				r.qidx  = QIDX_W'($urandom);
				n_load--;
				loads_done++;
			end else begin
				r.act   = ACT_QUERY;
				r.first = ($urandom_range(0, 7) == 0);
				r.px    = POS_W'($urandom);
				r.py    = POS_W'($urandom);
				r.pz    = POS_W'($urandom);
				r.anch  = 1'($urandom_range(0, 1));
				if (mesh_cnt > 0 && $urandom_range(0, 7) != 0)
					r.qidx = QIDX_W'($urandom_range(0, mesh_cnt - 1));
				else
					r.qidx = QIDX_W'($urandom);
				n_query--;
			end
			issue(r);
		end
	endtask

	task automatic random_mesh();
		int pct;
		case ($urandom_range(0, 3))
			0: pct = 0;
			1: pct = 10;
			2: pct = 40;
			default: pct = 100;
		endcase
		run_mesh($urandom_range(1, 40), $urandom_range(1, 24),
			coord_mode_t'($urandom_range(0, 2)), pct, $urandom_range(0, 7) != 0);
	endtask

	function automatic dir_row_t make_row(input logic act, input logic first,
			input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic anch, input logic [QIDX_W-1:0] qidx,
			input chk_mode_t mode, input int aidx, input int tlen, input logic none);
		dir_row_t row;
		row.req.act   = act;
		row.req.first = first;
		row.req.px    = px;
		row.req.py    = py;
		row.req.pz    = pz;
		row.req.anch  = anch;
		row.req.qidx  = qidx;
		row.mode      = mode;
		row.want.aidx = AIDX_W'(aidx);
		row.want.tlen = TLEN_W'(tlen);
		row.want.none = none;
		return row;
	endfunction

	task automatic tether_check();
		tether_t want;
		if (tether_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser));
			return;
		end
		want = tether_due.pop_front();
		if (m_tdata[AIDX_W-1:0] !== want.aidx)
			flag_mismatch($sformatf("anchor_index %0d, expected %0d",
				m_tdata[AIDX_W-1:0], want.aidx));
		if (m_tdata[AIDX_W +: TLEN_W] !== want.tlen)
			flag_mismatch($sformatf("tether_length %0d, expected %0d",
				m_tdata[AIDX_W +: TLEN_W], want.tlen));
		if (m_tuser !== want.none)
			flag_mismatch($sformatf("no_anchor %b, expected %b", m_tuser, want.none));
	endtask

	// Result side: check each transfer, stall in random bursts
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tether_check();
			if (stall > 0)
				stall--;
			else if (rx_idle_en && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 13);
			m_tready <= (stall == 0);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		bit      got;
		tether_t res;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;

		// Directed rows: empty mesh, extremes, no anchor, out of range, tie
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 1, 16'h8000, 16'h8000, 16'h8000, 0, 0,
			CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 0, CHK_TYPED, 0, 0, 1));
		dir_rows.push_back(make_row(ACT_LOAD, 0, 16'h7fff, 16'h7fff, 16'h7fff, 1, 10'h3ff,
			CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 0, CHK_TYPED, 1, 113509, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 1, CHK_TYPED, 1, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 2, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 16'hffff, 16'hffff, 16'hffff, 1, 10'h3ff,
			CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 1, 0, 0, 0, 1, 0, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 0, 256, 0, 0, 1, 0, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 0, 128, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 2, CHK_TYPED, 0, 128, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 1, 0, 0, 0, 0, 2, CHK_TYPED, 0, 128, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 0, 16'hffff, 16'hffff, 16'hffff, 0, 10'h2aa,
			CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 3, CHK_MODEL, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 0, 16'h5555, 16'haaaa, 16'h5555, 1, 10'h155,
			CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 3, CHK_MODEL, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 10'h155, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 1, 16'haaaa, 16'h5555, 16'haaaa, 1, 4,
			CHK_MODEL, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_LOAD, 0, 0, 0, 16'h8000, 1, 0, CHK_NONE, 0, 0, 0));
		dir_rows.push_back(make_row(ACT_QUERY, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_req(dir_rows[i].req, got, res);
			case (dir_rows[i].mode)
				CHK_MODEL: begin
					if (got)
						tether_due.push_back(res);
				end
				CHK_TYPED: tether_due.push_back(dir_rows[i].want);
				default: ;
			endcase
		end
		drain_wait();

		// Small meshes, idling switched per mesh, occasional hold-off
		while (sent_cnt < PHASE_A_END) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) == 0)
				drain_wait();
			random_mesh();
		end

		// One mesh past the store limit with sparse anchors
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		drain_wait();
		run_mesh(MAX_PARTICLES + 6, 24, SPREAD_WIDE, 2, 1'b1);

		// Closing stretch at full rate
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		while (sent_cnt < TOTAL_ITEMS)
			random_mesh();

		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && tether_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/nat_pkg.sv
rtl/core/nat_isqrt.sv
rtl/core/nat_ctrl.sv
rtl/core/nat_dpath.sv
rtl/core/nearest_anchor_tether.sv
tb/tb_top.sv
